[sv/ilex_pkg.sv]
`timescale 1ns / 1ps

package ilex_pkg;

   localparam int MAX_TOKEN_LEN_DEFAULT = 64;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int VALUE_W  = 64;
   localparam int DIGIT_W  = 4;

   localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPX   = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWX  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPF   = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWF  = 8'h66;

   // Largest magnitude that can take one more digit without passing 2^63.
   localparam logic [VALUE_W-1:0] DEC_QUOT  = 64'd922337203685477580;
   localparam logic [VALUE_W-1:0] HEX_QUOT  = 64'h0800_0000_0000_0000;
   localparam logic [VALUE_W-1:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX   = 64'h7fff_ffff_ffff_ffff;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_SIGN  = 3'd1,
      PH_ZERO  = 3'd2,
      PH_DEC   = 3'd3,
      PH_HEX   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               sat;
   } acc_type;

   function automatic logic is_dec(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Hex digit value in the low four bits; bit 4 set when c is no hex digit.
   function automatic logic [DIGIT_W:0] hex_val(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (is_dec(c)) begin
         d = c - CH_ZERO;
      end else if ((c >= CH_LOWA) && (c <= CH_LOWF)) begin
         d = c - CH_LOWA + 8'd10;
      end else if ((c >= CH_UPA) && (c <= CH_UPF)) begin
         d = c - CH_UPA + 8'd10;
      end else begin
         d = 8'd16;
      end
      return d[DIGIT_W:0];
   endfunction

endpackage

[sv/ilex_accum.sv]
`timescale 1ns / 1ps

module ilex_accum (
   input  ilex_pkg::acc_type                 acc_cur,
   input  logic                              base_hex,
   input  logic [ilex_pkg::DIGIT_W-1:0]      digit,
   output ilex_pkg::acc_type                 acc_nxt
);
   import ilex_pkg::*;

   logic               too_big;
   logic [VALUE_W-1:0] scaled;
   logic [VALUE_W-1:0] digit_ext;

   assign digit_ext = {{(VALUE_W-DIGIT_W){1'b0}}, digit};

   always_comb begin
      if (base_hex) begin
         too_big = (acc_cur.mag > HEX_QUOT) ||
                   ((acc_cur.mag == HEX_QUOT) && (digit != '0));
         scaled  = {acc_cur.mag[VALUE_W-5:0], 4'b0000};
      end else begin
         too_big = (acc_cur.mag > DEC_QUOT) ||
                   ((acc_cur.mag == DEC_QUOT) && (digit == 4'd9));
         scaled  = {acc_cur.mag[VALUE_W-4:0], 3'b000} + {acc_cur.mag[VALUE_W-2:0], 1'b0};
      end
   end

   // Once saturated the magnitude stays pinned at 2^63.
   always_comb begin
      if (acc_cur.sat) begin
         acc_nxt = acc_cur;
      end else if (too_big) begin
         acc_nxt.mag = MAG_LIMIT;
         acc_nxt.sat = 1'b1;
      end else begin
         acc_nxt.mag = scaled + digit_ext;
         acc_nxt.sat = 1'b0;
      end
   end

endmodule

[sv/integer_literal_lexer_unit.sv]
`timescale 1ns / 1ps
// Path: a character accepted into the input register passes through the scan logic
// into the result register, from which its result transaction is offered; it waits
// in the input register while the result slot is full and rsp_ready is low.
// Throughput: one character per cycle while the result slot is free or drains;
// the scan state updates as each character moves into the result register.
// Reset clears both pipeline stages and returns the scanner to its start phase.

module integer_literal_lexer_unit #(
   parameter int MAX_TOKEN_LEN = ilex_pkg::MAX_TOKEN_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ilex_pkg::CHAR_W-1:0]      req_char_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ilex_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ilex_pkg::COUNT_W-1:0]     rsp_token_length,
   output logic signed [ilex_pkg::VALUE_W-1:0] rsp_value,
   output logic                             rsp_overflowed
);
   import ilex_pkg::*;

   localparam logic [COUNT_W-1:0] LEN_MAX = COUNT_W'(MAX_TOKEN_LEN);

   logic                in_valid_ff;
   logic [CHAR_W-1:0]   in_char_ff;
   logic                out_valid_ff;
   logic [STATUS_W-1:0] status_ff,  status_in;
   logic [COUNT_W-1:0]  length_ff,  length_in;
   logic [VALUE_W-1:0]  value_ff,   value_in;
   logic                ovf_ff,     ovf_in;

   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [VALUE_W-1:0]  mag_ff,   mag_in;
   logic                neg_ff,   neg_in;
   logic                sat_ff,   sat_in;

   logic                advance;
   logic                at_start;
   logic [COUNT_W-1:0]  eff_count;
   logic [COUNT_W-1:0]  count_inc;
   acc_type             acc_cur, acc_nxt;
   logic                c_dec, c_hex, c_sign, c_x, c_zero;
   logic [DIGIT_W:0]    hv;
   logic [CHAR_W-1:0]   dec_off;
   logic [DIGIT_W-1:0]  digit;

   // Handshake: the input register moves on whenever the result slot is free or being read out.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_in;
      end
   end

   // Character classes.
   assign c_dec   = is_dec(in_char_ff);
   assign hv      = hex_val(in_char_ff);
   assign c_hex   = !hv[DIGIT_W];
   assign c_sign  = (in_char_ff == CH_PLUS) || (in_char_ff == CH_MINUS);
   assign c_x     = (in_char_ff == CH_LOWX) || (in_char_ff == CH_UPX);
   assign c_zero  = (in_char_ff == CH_ZERO);
   assign dec_off = in_char_ff - CH_ZERO;
   assign digit   = (phase_ff == PH_HEX) ? hv[DIGIT_W-1:0] : dec_off[DIGIT_W-1:0];

   // The start phase (and any unused code) begins from a cleared scan.
   always_comb begin
      case (phase_ff)
         PH_SIGN, PH_ZERO, PH_DEC, PH_HEX: at_start = 1'b0;
         default:                          at_start = 1'b1;
      endcase
   end

   assign eff_count   = at_start ? '0 : count_ff;
   assign count_inc   = (eff_count < LEN_MAX) ? eff_count + 1'b1 : eff_count;
   assign acc_cur.mag = at_start ? '0 : mag_ff;
   assign acc_cur.sat = at_start ? 1'b0 : sat_ff;

   ilex_accum u_accum (
      .acc_cur  (acc_cur),
      .base_hex (phase_ff == PH_HEX),
      .digit    (digit),
      .acc_nxt  (acc_nxt)
   );

   // Next scan state.
   always_comb begin
      phase_in = PH_START;
      count_in = '0;
      mag_in   = '0;
      neg_in   = 1'b0;
      sat_in   = 1'b0;
      case (phase_ff)
         PH_SIGN: begin
            if (c_dec) begin
               count_in = count_inc;
               neg_in   = neg_ff;
               if (c_zero) begin
                  phase_in = PH_ZERO;
               end else begin
                  phase_in = PH_DEC;
                  mag_in   = acc_nxt.mag;
                  sat_in   = acc_nxt.sat;
               end
            end
         end
         PH_ZERO, PH_DEC: begin
            if ((phase_ff == PH_ZERO) && c_x) begin
               phase_in = PH_HEX;
               count_in = count_inc;
               mag_in   = mag_ff;
               neg_in   = neg_ff;
               sat_in   = sat_ff;
            end else if (c_dec) begin
               phase_in = PH_DEC;
               count_in = count_inc;
               mag_in   = acc_nxt.mag;
               neg_in   = neg_ff;
               sat_in   = acc_nxt.sat;
            end
         end
         PH_HEX: begin
            if (c_hex) begin
               phase_in = PH_HEX;
               count_in = count_inc;
               mag_in   = acc_nxt.mag;
               neg_in   = neg_ff;
               sat_in   = acc_nxt.sat;
            end
         end
         default: begin
            if (c_sign) begin
               phase_in = PH_SIGN;
               count_in = count_inc;
               neg_in   = (in_char_ff == CH_MINUS);
            end else if (c_zero) begin
               phase_in = PH_ZERO;
               count_in = count_inc;
            end else if (c_dec) begin
               phase_in = PH_DEC;
               count_in = count_inc;
               mag_in   = acc_nxt.mag;
               sat_in   = acc_nxt.sat;
            end
         end
      endcase
   end

   // Result of this character.
   always_comb begin
      status_in = ST_PENDING;
      length_in = '0;
      value_in  = '0;
      ovf_in    = 1'b0;
      case (phase_ff)
         PH_SIGN: begin
            if (!c_dec) begin
               status_in = ST_REJECT;
            end
         end
         PH_ZERO, PH_DEC, PH_HEX: begin
            if (!(c_dec || ((phase_ff == PH_ZERO) && c_x) ||
                  ((phase_ff == PH_HEX) && c_hex))) begin
               status_in = ST_ACCEPT;
               length_in = count_ff;
               if (neg_ff) begin
                  value_in = sat_ff ? MAG_LIMIT : ('0 - mag_ff);
                  ovf_in   = sat_ff;
               end else if (sat_ff || mag_ff[VALUE_W-1]) begin
                  value_in = VAL_MAX;
                  ovf_in   = 1'b1;
               end else begin
                  value_in = mag_ff;
               end
            end
         end
         default: begin
            if (!(c_sign || c_dec)) begin
               status_in = ST_REJECT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         count_ff     <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            mag_ff       <= mag_in;
            neg_ff       <= neg_in;
            sat_ff       <= sat_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         status_ff <= status_in;
         length_ff <= length_in;
         value_ff  <= value_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_token_length = length_ff;
   assign rsp_value        = value_ff;
   assign rsp_overflowed   = ovf_ff;

endmodule
